### rtl/core/mmaf_pkg.sv
// ----------------------------------------------------------------------------
// mmaf_pkg
// Shared types, codes and helpers for the fp32 matrix multiply-accumulate.
// ----------------------------------------------------------------------------
package mmaf_pkg;

  // signed exponent width inside the fma datapath
  localparam int EW = 12;

  localparam int QDEPTH = 4;
  localparam int QPW    = 2;

  localparam logic [2:0] CMD_WR_A = 3'd0;
  localparam logic [2:0] CMD_WR_B = 3'd1;
  localparam logic [2:0] CMD_WR_C = 3'd2;
  localparam logic [2:0] CMD_RUN  = 3'd3;
  localparam logic [2:0] CMD_RD_C = 3'd4;

  localparam logic RES_DONE = 1'b0;
  localparam logic RES_READ = 1'b1;

  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_INNER = 2'd1;
  localparam logic [1:0] REG_COLS  = 2'd2;

  localparam logic [31:0] QNAN_DEFAULT = 32'h7FC0_0000;
  localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

  typedef enum logic [2:0] {
    OP_WR_A,
    OP_WR_B,
    OP_WR_C,
    OP_RUN,
    OP_RD_C,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  idx;
    logic [31:0] value;
  } job_t;

  typedef struct packed {
    logic [4:0] rows_m;
    logic [4:0] inner_k;
    logic [4:0] cols_n;
  } dims_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RDOUT,
    BK_FETCH,
    BK_ISSUE,
    BK_WAIT,
    BK_FINISH
  } bk_state_t;

  // position of the highest set bit, 0 when none
  function automatic logic [5:0] top_bit64(input logic [63:0] x);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) pos = 6'(i);
    end
    return pos;
  endfunction

endpackage

### rtl/core/mmaf_if.sv
// ----------------------------------------------------------------------------
// mmaf_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface mmaf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [7:0]  element_index;
  logic [31:0] element_value;

  modport source(output valid, command, element_index, element_value, input ready);
  modport sink(input valid, command, element_index, element_value, output ready);
endinterface

interface mmaf_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] result_value;

  modport source(output valid, result_kind, result_value, input ready);
  modport sink(input valid, result_kind, result_value, output ready);
endinterface

### rtl/core/mmaf_front.sv
// ----------------------------------------------------------------------------
// mmaf_front
// Decodes command words and queues them for the back end.
// ----------------------------------------------------------------------------
module mmaf_front (
  input  logic              clk,
  input  logic              rst_n,
  mmaf_in_if.sink           in_ch,
  output logic              q_valid,
  output mmaf_pkg::job_t    q_job,
  input  logic              q_pop
);

  mmaf_pkg::job_t          q_r [mmaf_pkg::QDEPTH];
  logic [mmaf_pkg::QPW:0]  cnt_r;
  logic [mmaf_pkg::QPW-1:0] wp_r;
  logic [mmaf_pkg::QPW-1:0] rp_r;
  mmaf_pkg::op_t           op;
  logic                    push;

  always_comb begin
    case (in_ch.command)
      mmaf_pkg::CMD_WR_A: op = mmaf_pkg::OP_WR_A;
      mmaf_pkg::CMD_WR_B: op = mmaf_pkg::OP_WR_B;
      mmaf_pkg::CMD_WR_C: op = mmaf_pkg::OP_WR_C;
      mmaf_pkg::CMD_RUN:  op = mmaf_pkg::OP_RUN;
      mmaf_pkg::CMD_RD_C: op = mmaf_pkg::OP_RD_C;
      default:            op = mmaf_pkg::OP_NOP;
    endcase
  end

  assign in_ch.ready = (cnt_r != (mmaf_pkg::QPW+1)'(mmaf_pkg::QDEPTH));
  // unknown commands are taken and dropped here
  assign push    = in_ch.valid && in_ch.ready && (op != mmaf_pkg::OP_NOP);
  assign q_valid = (cnt_r != '0);
  assign q_job   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= '0;
      rp_r  <= '0;
    end else begin
      if (push)  wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (mmaf_pkg::QPW+1)'(push) - (mmaf_pkg::QPW+1)'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{op: op, idx: in_ch.element_index, value: in_ch.element_value};
    end
  end

endmodule

### rtl/core/mmaf_fma.sv
// ----------------------------------------------------------------------------
// mmaf_fma
// Seven-stage binary32 fused multiply-add, round to nearest even.
// ----------------------------------------------------------------------------
module mmaf_fma (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  output logic        done,
  output logic [31:0] res
);

  localparam int EW = mmaf_pkg::EW;

  logic [6:0] vld_r;

  // stage 1: unpack, specials, mantissa product
  logic                 na, nb, nc, ia, ib, ic, za, zb, zc, sp, sc;
  logic                 spec1;
  logic [31:0]          sv1;
  logic [23:0]          ma, mb, mc;
  logic signed [EW-1:0] ea, eb, ec;
  logic [47:0]          p1_r;
  logic [23:0]          mc1_r;
  logic signed [EW-1:0] ep1_r, ec1_r;
  logic                 sp1_r, sc1_r, cz1_r, spec1_r;
  logic [31:0]          sv1_r;

  assign na = a[30:0] > 31'h7F80_0000;
  assign nb = b[30:0] > 31'h7F80_0000;
  assign nc = c[30:0] > 31'h7F80_0000;
  assign ia = a[30:0] == 31'h7F80_0000;
  assign ib = b[30:0] == 31'h7F80_0000;
  assign ic = c[30:0] == 31'h7F80_0000;
  assign za = a[30:0] == '0;
  assign zb = b[30:0] == '0;
  assign zc = c[30:0] == '0;
  assign sp = a[31] ^ b[31];
  assign sc = c[31];

  assign ma = {a[30:23] != '0, a[22:0]};
  assign mb = {b[30:23] != '0, b[22:0]};
  assign mc = {c[30:23] != '0, c[22:0]};
  assign ea = (a[30:23] == '0) ? EW'(-149) : EW'({4'b0, a[30:23]}) - EW'(150);
  assign eb = (b[30:23] == '0) ? EW'(-149) : EW'({4'b0, b[30:23]}) - EW'(150);
  assign ec = (c[30:23] == '0) ? EW'(-149) : EW'({4'b0, c[30:23]}) - EW'(150);

  always_comb begin
    spec1 = 1'b1;
    sv1   = '0;
    if (na) sv1 = a | mmaf_pkg::QUIET_BIT;
    else if (nb) sv1 = b | mmaf_pkg::QUIET_BIT;
    else if (nc) sv1 = c | mmaf_pkg::QUIET_BIT;
    else if (ia || ib) begin
      if (za || zb) sv1 = mmaf_pkg::QNAN_DEFAULT;
      else if (ic && (sc != sp)) sv1 = mmaf_pkg::QNAN_DEFAULT;
      else sv1 = {sp, 8'hFF, 23'b0};
    end
    else if (ic) sv1 = c;
    else if ((za || zb) && zc) sv1 = (sp == sc) ? {sp, 31'b0} : 32'b0;
    else if (za || zb) sv1 = c;
    else spec1 = 1'b0;
  end

  always_ff @(posedge clk) begin
    p1_r    <= ma * mb;
    ep1_r   <= ea + eb;
    mc1_r   <= mc;
    ec1_r   <= ec;
    sp1_r   <= sp;
    sc1_r   <= sc;
    cz1_r   <= zc;
    spec1_r <= spec1;
    sv1_r   <= sv1;
  end

  // stage 2: normalize both addends to bit 60
  logic [5:0]           tp, tc;
  logic [63:0]          pn2_r, cn2_r;
  logic signed [EW-1:0] ep2_r, ec2_r;
  logic                 sp2_r, sc2_r, cz2_r, spec2_r;
  logic [31:0]          sv2_r;

  assign tp = mmaf_pkg::top_bit64({16'b0, p1_r});
  assign tc = mmaf_pkg::top_bit64({40'b0, mc1_r});

  always_ff @(posedge clk) begin
    pn2_r   <= {16'b0, p1_r} << (6'd60 - tp);
    cn2_r   <= {40'b0, mc1_r} << (6'd60 - tc);
    ep2_r   <= ep1_r - EW'(6'd60 - tp);
    ec2_r   <= ec1_r - EW'(6'd60 - tc);
    sp2_r   <= sp1_r;
    sc2_r   <= sc1_r;
    cz2_r   <= cz1_r;
    spec2_r <= spec1_r;
    sv2_r   <= sv1_r;
  end

  // stage 3: order by exponent, align the smaller with sticky
  logic                 p_big;
  logic [63:0]          big, small_raw, small_al, lost_mask;
  logic signed [EW-1:0] ebig, dif;
  logic [5:0]           d6;
  logic [63:0]          big3_r, small3_r;
  logic signed [EW-1:0] e3_r;
  logic                 sbig3_r, ssm3_r, spec3_r;
  logic [31:0]          sv3_r;

  assign p_big     = cz2_r || (ep2_r >= ec2_r);
  assign big       = p_big ? pn2_r : cn2_r;
  assign small_raw = p_big ? cn2_r : pn2_r;
  assign ebig      = p_big ? ep2_r : ec2_r;
  assign dif       = p_big ? (ep2_r - ec2_r) : (ec2_r - ep2_r);
  assign d6        = dif[5:0];
  assign lost_mask = (64'd1 << d6) - 64'd1;

  always_comb begin
    if (cz2_r) small_al = '0;
    else if (dif >= EW'(63)) small_al = 64'd1;
    else small_al = (small_raw >> d6) | {63'b0, (small_raw & lost_mask) != '0};
  end

  always_ff @(posedge clk) begin
    big3_r   <= big;
    small3_r <= small_al;
    e3_r     <= ebig;
    sbig3_r  <= p_big ? sp2_r : sc2_r;
    ssm3_r   <= p_big ? sc2_r : sp2_r;
    spec3_r  <= spec2_r;
    sv3_r    <= sv2_r;
  end

  // stage 4: signed magnitude add
  logic [63:0]          r4;
  logic                 sg4, eqz4;
  logic [63:0]          r4_r;
  logic signed [EW-1:0] e4_r;
  logic                 sg4_r, spec4_r;
  logic [31:0]          sv4_r;

  always_comb begin
    eqz4 = 1'b0;
    sg4  = sbig3_r;
    r4   = big3_r + small3_r;
    if (sbig3_r != ssm3_r) begin
      if (big3_r > small3_r) r4 = big3_r - small3_r;
      else if (small3_r > big3_r) begin
        r4  = small3_r - big3_r;
        sg4 = ssm3_r;
      end else begin
        r4   = '0;
        eqz4 = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    r4_r    <= r4;
    e4_r    <= e3_r;
    sg4_r   <= sg4;
    spec4_r <= spec3_r || eqz4;
    sv4_r   <= spec3_r ? sv3_r : 32'b0;
  end

  // stage 5: rounding position, clamped at the subnormal floor
  logic signed [EW-1:0] sh5, lim5;
  logic [63:0]          r5_r;
  logic signed [EW-1:0] e5_r, s5_r;
  logic                 sg5_r, spec5_r;
  logic [31:0]          sv5_r;

  assign sh5  = EW'(mmaf_pkg::top_bit64(r4_r)) - EW'(23);
  assign lim5 = EW'(-149) - e4_r;

  always_ff @(posedge clk) begin
    r5_r    <= r4_r;
    e5_r    <= e4_r;
    s5_r    <= (lim5 > sh5) ? lim5 : sh5;
    sg5_r   <= sg4_r;
    spec5_r <= spec4_r;
    sv5_r   <= sv4_r;
  end

  // stage 6: shift and round decision
  logic [5:0]           sa6, ns6;
  logic [63:0]          rem6, half6;
  logic [23:0]          m6;
  logic                 rnd6;
  logic [23:0]          m6_r;
  logic                 rnd6_r, sg6_r, spec6_r;
  logic signed [EW-1:0] be6_r;
  logic [31:0]          sv6_r;

  assign sa6   = s5_r[5:0];
  assign ns6   = 6'(-s5_r);
  assign rem6  = r5_r & ((64'd1 << sa6) - 64'd1);
  assign half6 = 64'd1 << (sa6 - 6'd1);

  always_comb begin
    m6   = '0;
    rnd6 = 1'b0;
    if (s5_r <= EW'(0)) m6 = 24'(r5_r << ns6);
    else if (s5_r < EW'(64)) begin
      m6   = 24'(r5_r >> sa6);
      rnd6 = (rem6 > half6) || ((rem6 == half6) && m6[0]);
    end
  end

  always_ff @(posedge clk) begin
    m6_r    <= m6;
    rnd6_r  <= rnd6;
    be6_r   <= e5_r + s5_r + EW'(149);
    sg6_r   <= sg5_r;
    spec6_r <= spec5_r;
    sv6_r   <= sv5_r;
  end

  // stage 7: pack with carry into the exponent, overflow to infinity
  logic [24:0] m7;
  logic [35:0] total7;
  logic [31:0] res_r;

  assign m7     = {1'b0, m6_r} + 25'(rnd6_r);
  assign total7 = (36'(unsigned'(be6_r)) << 23) + 36'(m7);

  always_ff @(posedge clk) begin
    if (spec6_r) res_r <= sv6_r;
    else if (m7 == '0) res_r <= {sg6_r, 31'b0};
    else if (total7 >= 36'h7F80_0000) res_r <= {sg6_r, 8'hFF, 23'b0};
    else res_r <= {sg6_r, total7[30:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[5:0], start};
  end

  assign done = vld_r[6];
  assign res  = res_r;

endmodule

### rtl/core/mmaf_back.sv
// ----------------------------------------------------------------------------
// mmaf_back
// Operand stores, run sequencer over i, p, j and the result register.
// ----------------------------------------------------------------------------
module mmaf_back #(
  parameter int MAX_DIM = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mmaf_pkg::dims_t   dims,
  input  logic              q_valid,
  input  mmaf_pkg::job_t    q_job,
  output logic              q_pop,
  mmaf_out_if.source        out_ch
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CW    = (DW > 5) ? DW : 5;

  logic [31:0] mem_a [DEPTH];
  logic [31:0] mem_b [DEPTH];
  logic [31:0] mem_c [DEPTH];

  mmaf_pkg::bk_state_t state_r, state_nxt;

  logic [DW-1:0] dm, dk, dn;
  logic [DW-1:0] i_r, p_r, j_r;
  logic [AW-1:0] a_base_r, b_base_r, c_base_r;
  logic [AW-1:0] a_addr, b_addr, c_addr, job_addr, rd_c_addr, wr_c_addr;
  logic [31:0]   rd_a_r, rd_b_r, rd_c_r, wr_c_data;
  logic          idx_ok, rd_ok_r, any_zero, last;
  logic          wr_a_en, wr_b_en, wr_c_en, cnt_init, cnt_step, fma_start;
  logic          fma_done;
  logic [31:0]   fma_res;
  logic          out_load, out_kind;
  logic [31:0]   out_value;
  logic          out_valid_r, out_kind_r;
  logic [31:0]   out_value_r;

  function automatic logic [DW-1:0] clamp_dim(input logic [4:0] v);
    logic [CW-1:0] x;
    x = CW'(v);
    return (x > CW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(x);
  endfunction

  assign dm = clamp_dim(dims.rows_m);
  assign dk = clamp_dim(dims.inner_k);
  assign dn = clamp_dim(dims.cols_n);
  assign any_zero = (dm == '0) || (dk == '0) || (dn == '0);
  assign last = (j_r == dn - 1'b1) && (p_r == dk - 1'b1) && (i_r == dm - 1'b1);

  assign idx_ok   = 32'(q_job.idx) < DEPTH;
  assign job_addr = AW'(q_job.idx);
  assign a_addr   = a_base_r + AW'(p_r);
  assign b_addr   = b_base_r + AW'(j_r);
  assign c_addr   = c_base_r + AW'(j_r);

  mmaf_fma u_fma (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fma_start),
    .a     (rd_a_r),
    .b     (rd_b_r),
    .c     (rd_c_r),
    .done  (fma_done),
    .res   (fma_res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mmaf_pkg::BK_IDLE: begin
        if (q_valid && !out_valid_r) begin
          if (q_job.op == mmaf_pkg::OP_RD_C) state_nxt = mmaf_pkg::BK_RDOUT;
          else if (q_job.op == mmaf_pkg::OP_RUN) begin
            state_nxt = any_zero ? mmaf_pkg::BK_FINISH : mmaf_pkg::BK_FETCH;
          end
        end
      end
      mmaf_pkg::BK_RDOUT:  state_nxt = mmaf_pkg::BK_IDLE;
      mmaf_pkg::BK_FETCH:  state_nxt = mmaf_pkg::BK_ISSUE;
      mmaf_pkg::BK_ISSUE:  state_nxt = mmaf_pkg::BK_WAIT;
      mmaf_pkg::BK_WAIT: begin
        if (fma_done) state_nxt = last ? mmaf_pkg::BK_FINISH : mmaf_pkg::BK_FETCH;
      end
      mmaf_pkg::BK_FINISH: state_nxt = mmaf_pkg::BK_IDLE;
      default:             state_nxt = mmaf_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    wr_a_en   = 1'b0;
    wr_b_en   = 1'b0;
    wr_c_en   = 1'b0;
    wr_c_addr = job_addr;
    wr_c_data = q_job.value;
    rd_c_addr = c_addr;
    cnt_init  = 1'b0;
    cnt_step  = 1'b0;
    fma_start = 1'b0;
    out_load  = 1'b0;
    out_kind  = mmaf_pkg::RES_DONE;
    out_value = '0;
    case (state_r)
      mmaf_pkg::BK_IDLE: begin
        rd_c_addr = job_addr;
        if (q_valid) begin
          case (q_job.op)
            mmaf_pkg::OP_WR_A: begin
              q_pop   = 1'b1;
              wr_a_en = idx_ok;
            end
            mmaf_pkg::OP_WR_B: begin
              q_pop   = 1'b1;
              wr_b_en = idx_ok;
            end
            mmaf_pkg::OP_WR_C: begin
              q_pop   = 1'b1;
              wr_c_en = idx_ok;
            end
            mmaf_pkg::OP_RD_C: q_pop = !out_valid_r;
            mmaf_pkg::OP_RUN: begin
              q_pop    = !out_valid_r;
              cnt_init = !out_valid_r;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      mmaf_pkg::BK_RDOUT: begin
        out_load  = 1'b1;
        out_kind  = mmaf_pkg::RES_READ;
        out_value = rd_ok_r ? rd_c_r : 32'b0;
      end
      mmaf_pkg::BK_ISSUE: fma_start = 1'b1;
      mmaf_pkg::BK_WAIT: begin
        if (fma_done) begin
          wr_c_en   = 1'b1;
          wr_c_addr = c_addr;
          wr_c_data = fma_res;
          cnt_step  = 1'b1;
        end
      end
      mmaf_pkg::BK_FINISH: out_load = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mmaf_pkg::BK_IDLE;
    else state_r <= state_nxt;
  end

  // loop counters; row bases track i*k, p*n and i*n without multipliers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r      <= '0;
      p_r      <= '0;
      j_r      <= '0;
      a_base_r <= '0;
      b_base_r <= '0;
      c_base_r <= '0;
    end else if (cnt_init) begin
      i_r      <= '0;
      p_r      <= '0;
      j_r      <= '0;
      a_base_r <= '0;
      b_base_r <= '0;
      c_base_r <= '0;
    end else if (cnt_step) begin
      if (j_r != dn - 1'b1) j_r <= j_r + 1'b1;
      else begin
        j_r <= '0;
        if (p_r != dk - 1'b1) begin
          p_r      <= p_r + 1'b1;
          b_base_r <= b_base_r + AW'(dn);
        end else begin
          p_r      <= '0;
          b_base_r <= '0;
          i_r      <= i_r + 1'b1;
          a_base_r <= a_base_r + AW'(dk);
          c_base_r <= c_base_r + AW'(dn);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a_en) mem_a[job_addr] <= q_job.value;
    if (wr_b_en) mem_b[job_addr] <= q_job.value;
    if (wr_c_en) mem_c[wr_c_addr] <= wr_c_data;
    rd_a_r  <= mem_a[a_addr];
    rd_b_r  <= mem_b[b_addr];
    rd_c_r  <= mem_c[rd_c_addr];
    rd_ok_r <= idx_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r  <= out_kind;
      out_value_r <= out_value;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_kind_r;
  assign out_ch.result_value = out_value_r;

endmodule

### rtl/core/matrix_multiply_accumulate_fp32.sv
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_fp32
// fp32 C += A x B over local stores, loaded and read one word at a time.
// ----------------------------------------------------------------------------
// Writes retire one per cycle from a 4-word queue while the back end is idle; a read
// result is loaded from a store read in BK_IDLE into the result register in BK_RDOUT.
// In a run each C update goes store read, issue, 7-stage fma, write-back. Up to 4 input
// words queue in a run or behind a read/run held by a pending result, then input stalls.
// Reset clears control state and sets m, k, n to 1; store contents are
// undefined until written.
module matrix_multiply_accumulate_fp32 #(
  parameter int MAX_DIM = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  mmaf_in_if.sink     in_ch,
  mmaf_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0]      rows_r, inner_r, cols_r;
  logic            cfg_wr;
  logic            q_valid, q_pop;
  mmaf_pkg::job_t  q_job;
  mmaf_pkg::dims_t dims;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= 5'd1;
      inner_r <= 5'd1;
      cols_r  <= 5'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        mmaf_pkg::REG_ROWS:  rows_r  <= pwdata[4:0];
        mmaf_pkg::REG_INNER: inner_r <= pwdata[4:0];
        mmaf_pkg::REG_COLS:  cols_r  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mmaf_pkg::REG_ROWS:  prdata = {27'b0, rows_r};
      mmaf_pkg::REG_INNER: prdata = {27'b0, inner_r};
      mmaf_pkg::REG_COLS:  prdata = {27'b0, cols_r};
      default:             prdata = '0;
    endcase
  end

  assign dims = '{rows_m: rows_r, inner_k: inner_r, cols_n: cols_r};

  mmaf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_job   (q_job),
    .q_pop   (q_pop)
  );

  mmaf_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .dims    (dims),
    .q_valid (q_valid),
    .q_job   (q_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");

  a_queue_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !q_pop) |=> q_valid)
    else $error("queued word lost");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.result_kind == mmaf_pkg::RES_DONE))
      |-> (out_ch.result_value == 32'b0))
    else $error("run-finished word carries data");

endmodule
